@@ rtl/barometric_pressure_compensation_macros.svh @@
// Assertion macros for the barometric pressure compensation block.
// Used by the top level only; expects signals named clk and rst in scope.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bpc_pkg.sv @@
// Shared types, widths and constants for the barometric pressure compensation block.
// No dependencies; every module imports this package.
package bpc_pkg;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Raw converter count width.
  localparam int COUNT_BITS = 10;

  localparam int COEFF_W     = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int PRESS_W     = 16;
  localparam int TEMP_W      = 12;
  localparam int NSTAGE      = 6;

  localparam int IN_TDATA_W  = ((2 * COUNT_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PRESS_W + TEMP_W + 7) / 8) * 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SLOPE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP        = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS       = CFG_IDX_W'(3);

  // Pressure path widths: polynomial is kept at a 2^-24 scale.
  localparam int CT_W  = imax(COEFF_W + 11, COEFF_W + COUNT_BITS) + 1;
  localparam int B2T_W = COEFF_W + COUNT_BITS;
  localparam int PP_W  = CT_W + COUNT_BITS;
  localparam int OFF_W = imax(COEFF_W + 21, B2T_W + 10) + 1;
  localparam int PC_W  = imax(PP_W, OFF_W) + 1;
  localparam int Z_W   = PC_W + 15;
  localparam int W_W   = Z_W - 24;

  // z = 10400*pc + 1023*2^23 + 8000*1023*2^24; the last term shifts the
  // in-range quotient to start at zero.
  localparam logic signed [63:0] Z_BIAS = 64'sd16369023 * (64'sd1 <<< 23);
  localparam int PR_LIMIT  = 65536 * 1023;
  localparam int WC_W      = 26;
  localparam int PR_RECIP  = 67174465;   // ceil(2^36 / 1023)
  localparam int PR_SHIFT  = 36;
  localparam int PRM_W     = WC_W + 27;

  // Temperature path: u = 2048*107 + 202213 - 320*t, result floor(u/107) - 2048.
  localparam int T_BIAS    = 421349;
  localparam int U_W       = imax(9 + COUNT_BITS, 19) + 1;
  localparam int UC_W      = 19;
  localparam int T_RECIP   = 1254372;    // ceil(2^27 / 107)
  localparam int T_SHIFT   = 27;
  localparam int TP_W      = UC_W + 21;
  localparam logic [TEMP_W-1:0] TEMP_OFS = TEMP_W'(2048);
  localparam logic [TEMP_W-1:0] TEMP_MIN = TEMP_W'(2048);

  typedef struct packed {
    logic signed [COEFF_W-1:0] a0;
    logic signed [COEFF_W-1:0] b1;
    logic signed [COEFF_W-1:0] b2;
    logic signed [COEFF_W-1:0] c12;
  } cfg_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] valid;
  } pipe_ctrl_t;

endpackage

@@ rtl/bpc_cfg_regs.sv @@
// Calibration coefficient registers written through the configuration channel.
// Depends on bpc_pkg.
module bpc_cfg_regs import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]   cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OFFSET:      cfg.a0  <= cfg_data;
        CFG_PRESS_SLOPE: cfg.b1  <= cfg_data;
        CFG_TEMP:        cfg.b2  <= cfg_data;
        CFG_CROSS:       cfg.c12 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/bpc_pipe_ctrl.sv @@
// Valid bits and per-stage load enables for the compensation pipeline.
// Depends on bpc_pkg.
module bpc_pipe_ctrl import bpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_ready,
  output pipe_ctrl_t ctrl
);

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] en;

  // A stage loads when it is empty or its content moves on in this cycle.
  always_comb begin
    en[NSTAGE-1] = !valid[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign ctrl.en    = en;
  assign ctrl.valid = valid;

endmodule

@@ rtl/bpc_press_dp.sv @@
// Pressure datapath: polynomial, scaling by 65/1023 with rounding, saturation.
// Depends on bpc_pkg; stage enables come from bpc_pipe_ctrl.
module bpc_press_dp import bpc_pkg::*; (
  input  logic                  clk,
  input  pipe_ctrl_t            ctrl,
  input  cfg_t                  cfg,
  input  logic [COUNT_BITS-1:0] pressure_count,
  input  logic [COUNT_BITS-1:0] temperature_count,
  output logic [PRESS_W-1:0]    pressure_sixteenths_hpa,
  output logic                  pressure_clipped
);

  logic signed [CT_W-1:0]  c12_x, b1_x, tc_x, ct_next, ct;
  logic signed [B2T_W-1:0] b2_x, tb_x, b2t_next, b2t;
  logic [COUNT_BITS-1:0]   p1;
  logic signed [PP_W-1:0]  ct_x, p_x, pp;
  logic signed [OFF_W-1:0] off_next, off;
  logic signed [PC_W-1:0]  pc;
  logic signed [Z_W-1:0]   zx, z;
  logic signed [W_W-1:0]   w;
  logic [WC_W-1:0]         wc;
  logic                    lo4, hi4, lo5, hi5;
  logic [PRM_W-1:0]        prod;

  // Stage 1: (b1*2^11 + c12*t) and b2*t.
  assign c12_x    = CT_W'(cfg.c12);
  assign b1_x     = CT_W'(cfg.b1);
  assign tc_x     = CT_W'($signed({1'b0, temperature_count}));
  assign ct_next  = (b1_x <<< 11) + c12_x * tc_x;
  assign b2_x     = B2T_W'(cfg.b2);
  assign tb_x     = B2T_W'($signed({1'b0, temperature_count}));
  assign b2t_next = b2_x * tb_x;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      ct  <= ct_next;
      b2t <= b2t_next;
      p1  <= pressure_count;
    end
  end

  // Stage 2: times p, and the offset terms.
  assign ct_x     = PP_W'(ct);
  assign p_x      = PP_W'($signed({1'b0, p1}));
  assign off_next = (OFF_W'(cfg.a0) <<< 21) + (OFF_W'(b2t) <<< 10);

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      pp  <= ct_x * p_x;
      off <= off_next;
    end
  end

  // Stage 3: full polynomial at 2^-24.
  always_ff @(posedge clk) begin
    if (ctrl.en[2]) pc <= PC_W'(pp) + PC_W'(off);
  end

  // Stage 4: 10400*pc plus rounding and output offset, then drop 24 bits.
  assign zx = Z_W'(pc);
  assign z  = (zx <<< 13) + (zx <<< 11) + (zx <<< 7) + (zx <<< 5) + Z_W'(Z_BIAS);
  assign w  = z[Z_W-1:24];

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      lo4 <= w[W_W-1];
      hi4 <= !w[W_W-1] && (w >= W_W'(PR_LIMIT));
      wc  <= w[WC_W-1:0];
    end
  end

  // Stage 5: divide by 1023 through the reciprocal.
  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      prod <= PRM_W'(wc) * PRM_W'(PR_RECIP);
      lo5  <= lo4;
      hi5  <= hi4;
    end
  end

  // Stage 6: saturate into the output register.
  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      if (lo5) begin
        pressure_sixteenths_hpa <= '0;
      end else if (hi5) begin
        pressure_sixteenths_hpa <= '1;
      end else begin
        pressure_sixteenths_hpa <= prod[PR_SHIFT+PRESS_W-1:PR_SHIFT];
      end
      pressure_clipped <= lo5 || hi5;
    end
  end

endmodule

@@ rtl/bpc_temp_dp.sv @@
// Temperature datapath: conversion by -1/5.35 with rounding, delayed to match pressure.
// Depends on bpc_pkg; stage enables come from bpc_pipe_ctrl.
module bpc_temp_dp import bpc_pkg::*; (
  input  logic                  clk,
  input  pipe_ctrl_t            ctrl,
  input  logic [COUNT_BITS-1:0] temperature_count,
  output logic [TEMP_W-1:0]     temperature_sixteenths_c
);

  logic signed [U_W-1:0] tx, u;
  logic                  neg;
  logic [TP_W-1:0]       prod;
  logic [TEMP_W-1:0]     q;
  logic [TEMP_W-1:0]     tr3, tr4, tr5;

  assign tx = U_W'($signed({1'b0, temperature_count}));

  // Stage 1: u = bias - 320*t; negative u means the result clamps low.
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) u <= U_W'(T_BIAS) - ((tx <<< 8) + (tx <<< 6));
  end

  // Stage 2: divide by 107 through the reciprocal.
  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      neg  <= u[U_W-1];
      prod <= TP_W'(u[UC_W-1:0]) * TP_W'(T_RECIP);
    end
  end

  assign q = prod[T_SHIFT+TEMP_W-1:T_SHIFT];

  // Stage 3: remove the offset, then delay to the output stage.
  always_ff @(posedge clk) begin
    if (ctrl.en[2]) tr3 <= neg ? TEMP_MIN : (q - TEMP_OFS);
    if (ctrl.en[3]) tr4 <= tr3;
    if (ctrl.en[4]) tr5 <= tr4;
    if (ctrl.en[5]) temperature_sixteenths_c <= tr5;
  end

endmodule

@@ rtl/barometric_pressure_compensation.sv @@
// Top level of the barometric pressure compensation block.
// Depends on bpc_pkg, bpc_cfg_regs, bpc_pipe_ctrl, bpc_press_dp, bpc_temp_dp
// and the assertion macro header.

// The block takes one beat holding a raw pressure count and a raw temperature
// count and returns one beat with the compensated pressure in 1/16 hPa
// (saturated, with a clip flag on tuser) and the temperature in 1/16 degree
// Celsius. It is a six-stage pipeline that accepts one beat every cycle while
// the output is not stalled; the result leaves from the sixth stage. Each
// stage holds its own valid bit and loads whenever it is empty or drains,
// so a stall on the output backs up stage by stage and input tready falls
// only once all six stages are full. The stage depth is set by the 26 by 27
// bit reciprocal multiply that divides by 1023 and by the 28 by 10 bit
// polynomial multiply. Calibration words are written on the cfg channel,
// which is always ready, and must only change while no beat is in flight.
`include "barometric_pressure_compensation_macros.svh"

module barometric_pressure_compensation import bpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: pressure_count, temperature_count, zero fill.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: pressure_sixteenths_hpa, temperature_sixteenths_c, zero fill.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: pressure_clipped.
  output logic                   m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COEFF_W-1:0]     cfg_data
);

  cfg_t                  cfg;
  pipe_ctrl_t            ctrl;
  logic [COUNT_BITS-1:0] pressure_count;
  logic [COUNT_BITS-1:0] temperature_count;
  logic [PRESS_W-1:0]    pressure_sixteenths_hpa;
  logic [TEMP_W-1:0]     temperature_sixteenths_c;

  assign pressure_count    = s_axis_tdata[COUNT_BITS-1:0];
  assign temperature_count = s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .ctrl      (ctrl)
  );

  bpc_press_dp u_press (
    .clk                     (clk),
    .ctrl                    (ctrl),
    .cfg                     (cfg),
    .pressure_count          (pressure_count),
    .temperature_count       (temperature_count),
    .pressure_sixteenths_hpa (pressure_sixteenths_hpa),
    .pressure_clipped        (m_axis_tuser)
  );

  bpc_temp_dp u_temp (
    .clk                      (clk),
    .ctrl                     (ctrl),
    .temperature_count        (temperature_count),
    .temperature_sixteenths_c (temperature_sixteenths_c)
  );

  assign s_axis_tready = ctrl.en[0];
  assign m_axis_tvalid = ctrl.valid[NSTAGE-1];
  assign m_axis_tdata  = OUT_TDATA_W'({temperature_sixteenths_c, pressure_sixteenths_hpa});

  // A ready sink never throttles the input.
  `BPC_ASSERT_IMP(a_no_stall_when_ready, m_axis_tready, s_axis_tready, "input stalled with ready output")
  // Input backpressure only happens with every stage occupied.
  `BPC_ASSERT_IMP(a_stall_only_full, !s_axis_tready, (&ctrl.valid) && !m_axis_tready, "input stalled with room in pipe")
  // A beat moving from stage one into stage two is held in stage two in the next cycle.
  `BPC_ASSERT_NXT(a_stage_move, ctrl.valid[0] && ctrl.en[1], ctrl.valid[1], "beat lost between stages")
  // Clipped pressure sits at one end of the range.
  `BPC_ASSERT_IMP(a_clip_at_rail, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[15:0] == 16'h0000) || (m_axis_tdata[15:0] == 16'hFFFF), "clip flag off the rail")

endmodule
